### src/klv_pkg.sv
// Shared types, constants and the tag table for the KLV local set decoder.
// Used by every module under src; no dependencies of its own.
package klv_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned ScaleW = 23;

  typedef enum logic [1:0] {
    KIND_SCALED = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_TEXT   = 2'd2,
    KIND_TIME   = 2'd3
  } kind_e;

  // numeric mapping class: input code format and divisor form
  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_U16   = 3'd1,
    CLS_U32   = 3'd2,
    CLS_S16   = 3'd3,
    CLS_S32   = 3'd4,
    CLS_MILLI = 3'd5
  } cls_e;

  typedef struct packed {
    logic              known;
    kind_e             kind;
    logic [3:0]        width;
    cls_e              cls;
    logic [ScaleW-1:0] scale;
    logic              offset;
  } tag_info_t;

  typedef struct packed {
    logic [7:0]  tag;
    kind_e       kind;
    logic [63:0] raw;
    logic        missing;
    logic        bad;
    logic        last_of;
    logic        do_scale;
    logic        neg;
    logic        offset;
    cls_e        cls;
  } meta_t;

  typedef struct packed {
    meta_t             meta;
    logic [ScaleW-1:0] scale;
    logic [31:0]       mag_in;
  } job_t;

  // -900.0 in Q31.32
  localparam logic [63:0] OffsetQ32 = 64'hFFFF_FC7C_0000_0000;

  // attitude tags: 3*m*2^29 / (5*0x7fff), odd divisor, done as reciprocal multiply
  localparam logic [63:0] MilliDen = 64'd163835;
  localparam logic [63:0] MilliK64 = (64'hC000_0000_0000_0000 + MilliDen - 64'd1) / MilliDen;
  localparam logic [63:0] MilliL64 = (64'd81917 * 64'h2_0000_0000 + MilliDen - 64'd1) / MilliDen;
  localparam logic [46:0] MilliK   = MilliK64[46:0];
  localparam logic [35:0] MilliL   = MilliL64[35:0];

  function automatic tag_info_t mk_info(input kind_e k, input int unsigned w, input cls_e c,
                                        input int unsigned s, input logic o);
    tag_info_t r;
    r.known  = 1'b1;
    r.kind   = k;
    r.width  = 4'(w);
    r.cls    = c;
    r.scale  = ScaleW'(s);
    r.offset = o;
    return r;
  endfunction

  function automatic tag_info_t tag_info(input logic [7:0] t);
    tag_info_t r;
    r = '0;
    case (t) inside
      8'd2:                      r = mk_info(KIND_TIME, 8, CLS_NONE, 0, 1'b0);
      8'd5:                      r = mk_info(KIND_SCALED, 2, CLS_U16, 360, 1'b0);
      8'd6:                      r = mk_info(KIND_SCALED, 2, CLS_S16, 20, 1'b0);
      8'd7:                      r = mk_info(KIND_SCALED, 2, CLS_S16, 50, 1'b0);
      [8'd10:8'd12]:             r = mk_info(KIND_TEXT, 0, CLS_NONE, 0, 1'b0);
      8'd13, 8'd23, 8'd40:       r = mk_info(KIND_SCALED, 4, CLS_S32, 90, 1'b0);
      8'd14, 8'd19, 8'd24, 8'd41: r = mk_info(KIND_SCALED, 4, CLS_S32, 180, 1'b0);
      8'd15, 8'd25, 8'd42:       r = mk_info(KIND_SCALED, 2, CLS_U16, 19900, 1'b1);
      8'd16, 8'd17:              r = mk_info(KIND_SCALED, 2, CLS_U16, 180, 1'b0);
      8'd18, 8'd20:              r = mk_info(KIND_SCALED, 4, CLS_U32, 360, 1'b0);
      8'd21, 8'd57:              r = mk_info(KIND_SCALED, 4, CLS_U32, 5000000, 1'b0);
      8'd22:                     r = mk_info(KIND_SCALED, 2, CLS_U16, 10000, 1'b0);
      [8'd26:8'd33]:             r = mk_info(KIND_SCALED, 2, CLS_MILLI, 0, 1'b0);
      8'd43, 8'd44, 8'd56, 8'd65: r = mk_info(KIND_RAW, 1, CLS_NONE, 0, 1'b0);
      default:                   r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/klv_front.sv
// Byte parser: tracks tag/length/value phase and builds one request per result.
// Depends on klv_pkg.
module klv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                set_last_i,
  input  logic                space_i,
  output logic                push_o,
  output klv_pkg::job_t       job_o
);

  typedef enum logic [2:0] {
    PH_TAG = 3'b001,
    PH_LEN = 3'b010,
    PH_VAL = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  rem_q, rem_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  taken_q, taken_d;

  klv_pkg::tag_info_t info;
  logic               accept;
  logic               done;

  function automatic klv_pkg::job_t number_job(input klv_pkg::tag_info_t inf,
                                               input logic [7:0] t, input logic [63:0] acc,
                                               input logic [3:0] taken);
    klv_pkg::job_t j;
    logic [15:0]   c16;
    logic [31:0]   c32;
    logic          bad;
    logic          miss;
    logic          neg;
    logic [31:0]   m;
    c16  = acc[15:0];
    c32  = acc[31:0];
    bad  = taken < inf.width;
    miss = 1'b0;
    neg  = 1'b0;
    m    = acc[31:0];
    case (inf.cls)
      klv_pkg::CLS_S16, klv_pkg::CLS_MILLI: begin
        miss = c16 == 16'h8000;
        neg  = c16[15];
        m    = {16'd0, neg ? 16'(-c16) : c16};
      end
      klv_pkg::CLS_S32: begin
        miss = c32 == 32'h8000_0000;
        neg  = c32[31];
        m    = neg ? 32'(-c32) : c32;
      end
      default: ;
    endcase
    miss = miss & ~bad;
    j.meta.tag      = t;
    j.meta.kind     = inf.kind;
    j.meta.raw      = acc;
    j.meta.missing  = miss;
    j.meta.bad      = bad;
    j.meta.last_of  = 1'b1;
    j.meta.do_scale = (inf.kind == klv_pkg::KIND_SCALED) & ~bad & ~miss;
    j.meta.neg      = neg;
    j.meta.offset   = inf.offset;
    j.meta.cls      = inf.cls;
    j.scale         = inf.scale;
    j.mag_in        = m;
    return j;
  endfunction

  assign in_ready_o = space_i;
  assign accept     = in_valid_i & space_i;
  assign info       = klv_pkg::tag_info(tag_q);

  always_comb begin
    phase_d = phase_q;
    tag_d   = tag_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    taken_d = taken_q;
    push_o  = 1'b0;
    job_o   = '0;
    done    = 1'b0;
    if (accept) begin
      case (phase_q)
        PH_LEN: begin
          rem_d   = data_byte_i;
          acc_d   = '0;
          taken_d = '0;
          if (data_byte_i == 8'd0 || set_last_i) begin
            phase_d = PH_TAG;
            if (info.known && info.kind != klv_pkg::KIND_TEXT) begin
              push_o = 1'b1;
              job_o  = number_job(info, tag_q, 64'd0, 4'd0);
            end
          end else begin
            phase_d = PH_VAL;
          end
        end
        PH_VAL: begin
          rem_d = rem_q - 8'd1;
          done  = (rem_d == 8'd0) | set_last_i;
          if (done) phase_d = PH_TAG;
          if (info.known) begin
            if (info.kind == klv_pkg::KIND_TEXT) begin
              push_o              = 1'b1;
              job_o.meta.tag      = tag_q;
              job_o.meta.kind     = klv_pkg::KIND_TEXT;
              job_o.meta.raw      = {56'd0, data_byte_i};
              job_o.meta.last_of  = done;
              job_o.meta.cls      = klv_pkg::CLS_NONE;
            end else begin
              if (taken_q < info.width) begin
                acc_d   = {acc_q[55:0], data_byte_i};
                taken_d = taken_q + 4'd1;
              end
              if (done) begin
                push_o = 1'b1;
                job_o  = number_job(info, tag_q, acc_d, taken_d);
              end
            end
          end
        end
        default: begin
          tag_d   = data_byte_i;
          phase_d = set_last_i ? PH_TAG : PH_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      tag_q   <= '0;
      rem_q   <= '0;
      acc_q   <= '0;
      taken_q <= '0;
    end else begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      rem_q   <= rem_d;
      acc_q   <= acc_d;
      taken_q <= taken_d;
    end
  end

endmodule

### src/klv_fifo.sv
// Small request queue between the parser and the scaling pipeline.
// Depends on klv_pkg.
module klv_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  klv_pkg::job_t wdata_i,
  output logic          space_o,
  input  logic          pop_i,
  output logic          valid_o,
  output klv_pkg::job_t rdata_o
);

  klv_pkg::job_t                mem_q [klv_pkg::QDepth];
  logic [klv_pkg::QPtrW-1:0]    wr_q, rd_q;
  logic [klv_pkg::QCntW-1:0]    cnt_q;
  logic                         do_push, do_pop;

  assign space_o = cnt_q != klv_pkg::QCntW'(klv_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i & space_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= klv_pkg::QCntW'(klv_pkg::QDepth))
    else $error("queue count beyond depth");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not grow on push");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("request pushed into a full queue");

endmodule

### src/klv_back.sv
// Scaling pipeline: maps codes to Q31.32 in four stages and holds the result.
// Depends on klv_pkg.
module klv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  klv_pkg::job_t       q_job_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          tag_o,
  output logic [1:0]          kind_o,
  output logic [63:0]         raw_value_o,
  output logic signed [63:0]  scaled_value_o,
  output logic                value_missing_o,
  output logic                malformed_o,
  output logic                element_end_o
);

  logic           adv;
  logic           s1_v_q, s2_v_q, s3_v_q, o_v_q;
  klv_pkg::meta_t s1_m_q, s2_m_q, s3_m_q, o_m_q;
  logic [61:0]    s1_p_q;
  logic [56:0]    s2_x_q;
  logic [63:0]    s2_base_q;
  logic [63:0]    s3_mag_q;
  logic [63:0]    o_scaled_q;

  logic [61:0]    prod;
  logic [56:0]    x_d;
  logic [63:0]    base_d;
  logic [56:0]    fa, fb;
  logic [57:0]    fsum;
  logic [57:0]    flim;
  logic           corr;
  logic [63:0]    mag_d;
  logic [63:0]    scaled_d;

  assign adv     = ~o_v_q | out_ready_i;
  assign q_pop_o = adv & q_valid_i;

  // stage 1: one product per class
  always_comb begin
    if (q_job_i.meta.cls == klv_pkg::CLS_MILLI) begin
      prod = 62'(q_job_i.mag_in[14:0]) * 62'(klv_pkg::MilliK) + 62'(klv_pkg::MilliL);
    end else begin
      prod = 62'(q_job_i.scale) * 62'(q_job_i.mag_in);
    end
  end

  // stage 2: P*2^32 = P*Cq*B + P*Cr with B = 2^k-1; x holds the remainder term plus half
  always_comb begin
    case (s1_m_q.cls)
      klv_pkg::CLS_U16: begin
        x_d    = 57'(s1_p_q) + 57'h7fff;
        base_d = (64'(s1_p_q) << 16) + 64'(s1_p_q);
      end
      klv_pkg::CLS_U32: begin
        x_d    = 57'(s1_p_q) + 57'h7fff_ffff;
        base_d = 64'(s1_p_q);
      end
      klv_pkg::CLS_S16: begin
        x_d    = (57'(s1_p_q) << 2) + 57'h3fff;
        base_d = (64'(s1_p_q) << 17) + (64'(s1_p_q) << 2);
      end
      klv_pkg::CLS_S32: begin
        x_d    = (57'(s1_p_q) << 1) + 57'h3fff_ffff;
        base_d = 64'(s1_p_q) << 1;
      end
      klv_pkg::CLS_MILLI: begin
        x_d    = '0;
        base_d = 64'(s1_p_q[61:33]);
      end
      default: begin
        x_d    = '0;
        base_d = '0;
      end
    endcase
  end

  // stage 3: one fold of x by 2^k-1, then a single compare
  always_comb begin
    fa   = '0;
    fb   = '0;
    flim = '1;
    case (s2_m_q.cls)
      klv_pkg::CLS_U16: begin
        fa = s2_x_q >> 16; fb = 57'(s2_x_q[15:0]); flim = 58'h0ffff;
      end
      klv_pkg::CLS_U32: begin
        fa = s2_x_q >> 32; fb = 57'(s2_x_q[31:0]); flim = 58'hffff_ffff;
      end
      klv_pkg::CLS_S16: begin
        fa = s2_x_q >> 15; fb = 57'(s2_x_q[14:0]); flim = 58'h7fff;
      end
      klv_pkg::CLS_S32: begin
        fa = s2_x_q >> 31; fb = 57'(s2_x_q[30:0]); flim = 58'h7fff_ffff;
      end
      default: ;
    endcase
    fsum  = 58'(fa) + 58'(fb);
    corr  = (s2_m_q.cls != klv_pkg::CLS_MILLI) && (s2_m_q.cls != klv_pkg::CLS_NONE) &&
            (fsum >= flim);
    mag_d = s2_base_q + 64'(fa) + 64'(corr);
  end

  // stage 4: sign and offset
  always_comb begin
    if (!s3_m_q.do_scale) scaled_d = '0;
    else if (s3_m_q.offset) scaled_d = klv_pkg::OffsetQ32 + s3_mag_q;
    else if (s3_m_q.neg) scaled_d = 64'd0 - s3_mag_q;
    else scaled_d = s3_mag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (adv) begin
      s1_v_q <= q_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      o_v_q  <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_m_q     <= q_job_i.meta;
      s1_p_q     <= prod;
      s2_m_q     <= s1_m_q;
      s2_x_q     <= x_d;
      s2_base_q  <= base_d;
      s3_m_q     <= s2_m_q;
      s3_mag_q   <= mag_d;
      o_m_q      <= s3_m_q;
      o_scaled_q <= scaled_d;
    end
  end

  assign out_valid_o     = o_v_q;
  assign tag_o           = o_m_q.tag;
  assign kind_o          = o_m_q.kind;
  assign raw_value_o     = o_m_q.raw;
  assign scaled_value_o  = o_scaled_q;
  assign value_missing_o = o_m_q.missing;
  assign malformed_o     = o_m_q.bad;
  assign element_end_o   = o_m_q.last_of;

  a_unscaled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q && (o_m_q.kind != klv_pkg::KIND_SCALED) |-> o_scaled_q == '0)
    else $error("nonzero scaled value on unscaled kind");
  a_missing_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q && o_m_q.missing |-> !o_m_q.bad && o_scaled_q == '0)
    else $error("missing code with scaled value or malformed flag");
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q && !out_ready_i |=> o_v_q && $stable(o_m_q) && $stable(o_scaled_q))
    else $error("result changed while stalled");

endmodule

### src/klv_local_set_decoder.sv
// KLV local set decoder top level: parser, request queue, scaling pipeline.
// Takes one byte per cycle while the queue has space; the byte that closes a result pushes it into the queue.
// Sustained rate is one byte per cycle and at most one result per byte while output is ready;
// the 4-entry queue feeds the 4-stage scaler; output stalls back up into the queue.
// Asynchronous active-low reset returns the parser to expecting a tag byte, empties the queue.
module klv_local_set_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               set_last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         tag_o,
  output logic [1:0]         kind_o,
  output logic [63:0]        raw_value_o,
  output logic signed [63:0] scaled_value_o,
  output logic               value_missing_o,
  output logic               malformed_o,
  output logic               element_end_o
);

  logic          push, space, q_valid, pop;
  klv_pkg::job_t push_job, head_job;

  klv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .set_last_i  (set_last_i),
    .space_i     (space),
    .push_o      (push),
    .job_o       (push_job)
  );

  klv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .space_o (space),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (head_job)
  );

  klv_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_job_i         (head_job),
    .q_pop_o         (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tag_o           (tag_o),
    .kind_o          (kind_o),
    .raw_value_o     (raw_value_o),
    .scaled_value_o  (scaled_value_o),
    .value_missing_o (value_missing_o),
    .malformed_o     (malformed_o),
    .element_end_o   (element_end_o)
  );

endmodule
